@@ hdl/tsta_pkg.sv @@
// Shared widths, codes and controller/datapath interface types of the segment time allocator.
package tsta_pkg;

  localparam int POS_W   = 32;               // waypoint coordinate, signed Q16.16
  localparam int DIF_W   = 32;               // magnitude of a coordinate difference
  localparam int ROOT_W  = 33;               // root of a 66-bit radicand
  localparam int SQ_W    = 2 * ROOT_W;       // sum of three squares
  localparam int REM_W   = ROOT_W + 1;       // root remainder
  localparam int PROD_W  = ROOT_W + DIF_W;   // shared multiplier product
  localparam int CFG_W   = 16;               // Q8.8 limit registers
  localparam int SA_W    = ROOT_W + CFG_W;   // s * a
  localparam int VV_W    = 2 * CFG_W;        // v * v
  localparam int VA_W    = 2 * CFG_W;        // v * a
  localparam int DVD_W   = 58;               // divider dividend and quotient
  localparam int DVS_W   = 32;               // divider divisor
  localparam int DUR_W   = 32;               // duration, unsigned Q16.16
  localparam int IDX_W   = 2;                // configuration register index

  localparam logic [IDX_W-1:0] CFG_MAX_VELOCITY     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_ACCELERATION = 2'd1;
  localparam logic [CFG_W-1:0] CFG_RESET_VALUE      = 16'd256;

  localparam int MUL_SEL_W = 3;
  localparam logic [MUL_SEL_W-1:0] MUL_XX = 3'd0;
  localparam logic [MUL_SEL_W-1:0] MUL_YY = 3'd1;
  localparam logic [MUL_SEL_W-1:0] MUL_ZZ = 3'd2;
  localparam logic [MUL_SEL_W-1:0] MUL_SA = 3'd3;
  localparam logic [MUL_SEL_W-1:0] MUL_VV = 3'd4;
  localparam logic [MUL_SEL_W-1:0] MUL_VA = 3'd5;

  localparam logic SQRT_SRC_ACC = 1'b0;
  localparam logic SQRT_SRC_QUO = 1'b1;

  typedef struct packed {
    logic                 capture;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 acc_add;
    logic                 sqrt_start;
    logic                 sqrt_src;
    logic                 s_load;
    logic                 sa_load;
    logic                 vv_load;
    logic                 va_load;
    logic                 div_start;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic first_pt;
    logic short_seg;
    logic sqrt_busy;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

@@ hdl/trapezoid_segment_time_allocator_unit.sv @@
// Top level of the trapezoidal segment time allocator: controller, datapath and checks.
//
//  channel  direction  handshake              payload
//  in       in         in_valid / in_ready    in_pos_x, in_pos_y, in_pos_z, in_start_point
//  out      out        out_valid / out_ready  out_duration, out_short_segment, out_saturated
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One waypoint at a time. A start point or the first point only refreshes the stored point.
// For any other waypoint the 33-step root unit runs once for the length (and again for a
// short segment's time) and the 58-step divider once.
// Reset (synchronous, rst_n low) clears the stored point and sets both limits to 1.0.
// A result waits in the output register while the next waypoint is accepted; the
// controller stalls before its own output load only while that register is still full.
module trapezoid_segment_time_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tsta_pkg::POS_W-1:0]    in_pos_x,
  input  logic [tsta_pkg::POS_W-1:0]    in_pos_y,
  input  logic [tsta_pkg::POS_W-1:0]    in_pos_z,
  input  logic                          in_start_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsta_pkg::DUR_W-1:0]    out_duration,
  output logic                          out_short_segment,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsta_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tsta_pkg::CFG_W-1:0]    cfg_data
);

  tsta_pkg::cmd_t    cmd;
  tsta_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tsta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tsta_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_start_point    (in_start_point),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_duration      (out_duration),
    .out_short_segment (out_short_segment),
    .out_saturated     (out_saturated)
  );

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register loaded while a beat is still pending");

  a_unit_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sqrt_start || cmd.div_start) |-> (!status.sqrt_busy && !status.div_busy))
    else $error("iterative unit started while one is busy");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_duration == {tsta_pkg::DUR_W{1'b1}}))
    else $error("saturated beat without maximum duration");

  a_short_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_short_segment) |-> !out_saturated)
    else $error("short segment reported as saturated");

  a_busy_after_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !status.first_pt) |=> !in_ready)
    else $error("segment beat accepted but input still ready");

endmodule

@@ hdl/tsta_sqrt.sv @@
// Iterative integer square root, one radicand bit pair per cycle.
module tsta_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsta_pkg::SQ_W-1:0]     radicand,
  output logic                          busy,
  output logic [tsta_pkg::ROOT_W-1:0]   root
);

  localparam int STEPS = tsta_pkg::SQ_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [tsta_pkg::SQ_W-1:0]   rad_r, rad_nxt;
  logic [tsta_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [tsta_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic [tsta_pkg::REM_W+1:0]  rem_s, trial, diff;

  always_comb begin
    rem_s    = {rem_r, rad_r[tsta_pkg::SQ_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_s - trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (rem_s >= trial) begin
        rem_nxt  = diff[tsta_pkg::REM_W-1:0];
        root_nxt = {root_r[tsta_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_s[tsta_pkg::REM_W-1:0];
        root_nxt = {root_r[tsta_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

@@ hdl/tsta_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tsta_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tsta_pkg::DVD_W-1:0]   dividend,
  input  logic [tsta_pkg::DVS_W-1:0]   divisor,
  output logic                         busy,
  output logic [tsta_pkg::DVD_W-1:0]   quotient
);

  localparam int STEPS = tsta_pkg::DVD_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [tsta_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [tsta_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [tsta_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [tsta_pkg::DVS_W:0]   rem_s, dvs_ext, diff;

  always_comb begin
    rem_s    = {rem_r, dvd_r[tsta_pkg::DVD_W-1]};
    dvs_ext  = {1'b0, dvs_r};
    diff     = rem_s - dvs_ext;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift the quotient bit in where the dividend bit left
      if (rem_s >= dvs_ext) begin
        rem_nxt = diff[tsta_pkg::DVS_W-1:0];
        dvd_nxt = {dvd_r[tsta_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_s[tsta_pkg::DVS_W-1:0];
        dvd_nxt = {dvd_r[tsta_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

@@ hdl/tsta_dp.sv @@
// Datapath: point store, shared multiplier, root and divide units, limit registers, output register.
module tsta_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tsta_pkg::POS_W-1:0]    in_pos_x,
  input  logic [tsta_pkg::POS_W-1:0]    in_pos_y,
  input  logic [tsta_pkg::POS_W-1:0]    in_pos_z,
  input  logic                          in_start_point,
  input  logic                          cfg_we,
  input  logic [tsta_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tsta_pkg::CFG_W-1:0]    cfg_data,
  input  tsta_pkg::cmd_t                cmd,
  output tsta_pkg::status_t             status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tsta_pkg::DUR_W-1:0]    out_duration,
  output logic                          out_short_segment,
  output logic                          out_saturated
);

  function automatic logic [tsta_pkg::DIF_W-1:0] abs_diff(
    input logic [tsta_pkg::POS_W-1:0] cur,
    input logic [tsta_pkg::POS_W-1:0] prev
  );
    logic [tsta_pkg::POS_W:0] d;
    logic [tsta_pkg::POS_W:0] m;
    d = {cur[tsta_pkg::POS_W-1], cur} - {prev[tsta_pkg::POS_W-1], prev};
    m = d[tsta_pkg::POS_W] ? ((tsta_pkg::POS_W+1)'(0) - d) : d;
    return m[tsta_pkg::DIF_W-1:0];
  endfunction

  logic [tsta_pkg::CFG_W-1:0]  vel_r, acl_r;
  logic [tsta_pkg::CFG_W-1:0]  v_eff, a_eff;
  logic [tsta_pkg::POS_W-1:0]  prev_x_r, prev_y_r, prev_z_r;
  logic                        have_prev_r;
  logic [tsta_pkg::DIF_W-1:0]  ax_r, ay_r, az_r;
  logic [tsta_pkg::SQ_W-1:0]   acc_r;
  logic [tsta_pkg::ROOT_W-1:0] mul_a;
  logic [tsta_pkg::DIF_W-1:0]  mul_b;
  logic [tsta_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic [tsta_pkg::ROOT_W-1:0] s_r;
  logic [tsta_pkg::SA_W-1:0]   sa_r;
  logic [tsta_pkg::VV_W-1:0]   vv_r;
  logic [tsta_pkg::VA_W-1:0]   va_r;
  logic                        short_r;
  logic [tsta_pkg::SQ_W-1:0]   radicand;
  logic                        sqrt_busy;
  logic [tsta_pkg::ROOT_W-1:0] root;
  logic [tsta_pkg::DVD_W-1:0]  dividend;
  logic [tsta_pkg::DVS_W-1:0]  divisor;
  logic                        div_busy;
  logic [tsta_pkg::DVD_W-1:0]  quotient;
  logic [tsta_pkg::DVD_W-1:0]  t_full;
  logic                        t_sat;
  logic                        out_valid_r;
  logic [tsta_pkg::DUR_W-1:0]  dur_r;
  logic                        short_out_r, sat_out_r;

  // a zero limit counts as one LSB (1/256 in Q8.8)
  assign v_eff = (vel_r == '0) ? tsta_pkg::CFG_W'(1) : vel_r;
  assign a_eff = (acl_r == '0) ? tsta_pkg::CFG_W'(1) : acl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= tsta_pkg::CFG_RESET_VALUE;
      acl_r <= tsta_pkg::CFG_RESET_VALUE;
    end else if (cfg_we) begin
      if (cfg_index == tsta_pkg::CFG_MAX_VELOCITY) begin
        vel_r <= cfg_data;
      end else if (cfg_index == tsta_pkg::CFG_MAX_ACCELERATION) begin
        acl_r <= cfg_data;
      end
    end
  end

  // previous point is taken over at acceptance; the differences already hold the segment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.capture) begin
      prev_x_r    <= in_pos_x;
      prev_y_r    <= in_pos_y;
      prev_z_r    <= in_pos_z;
      have_prev_r <= 1'b1;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      tsta_pkg::MUL_XX: begin
        mul_a = tsta_pkg::ROOT_W'(ax_r);
        mul_b = ax_r;
      end
      tsta_pkg::MUL_YY: begin
        mul_a = tsta_pkg::ROOT_W'(ay_r);
        mul_b = ay_r;
      end
      tsta_pkg::MUL_ZZ: begin
        mul_a = tsta_pkg::ROOT_W'(az_r);
        mul_b = az_r;
      end
      tsta_pkg::MUL_SA: begin
        mul_a = s_r;
        mul_b = tsta_pkg::DIF_W'(a_eff);
      end
      tsta_pkg::MUL_VV: begin
        mul_a = tsta_pkg::ROOT_W'(v_eff);
        mul_b = tsta_pkg::DIF_W'(v_eff);
      end
      tsta_pkg::MUL_VA: begin
        mul_a = tsta_pkg::ROOT_W'(v_eff);
        mul_b = tsta_pkg::DIF_W'(a_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.capture) begin
      ax_r  <= abs_diff(in_pos_x, prev_x_r);
      ay_r  <= abs_diff(in_pos_y, prev_y_r);
      az_r  <= abs_diff(in_pos_z, prev_z_r);
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {{(tsta_pkg::SQ_W-tsta_pkg::PROD_W){1'b0}}, prod_r};
    end
    if (cmd.s_load) begin
      s_r <= root;
    end
    if (cmd.sa_load) begin
      sa_r <= prod_r[tsta_pkg::SA_W-1:0];
    end
    if (cmd.vv_load) begin
      vv_r <= prod_r[tsta_pkg::VV_W-1:0];
    end
    if (cmd.va_load) begin
      va_r    <= prod_r[tsta_pkg::VA_W-1:0];
      short_r <= (sa_r <= tsta_pkg::SA_W'({vv_r, 8'b0}));
    end
  end

  assign radicand = (cmd.sqrt_src == tsta_pkg::SQRT_SRC_QUO) ?
                    tsta_pkg::SQ_W'({quotient, 2'b00}) : acc_r;

  always_comb begin
    if (short_r) begin
      dividend = tsta_pkg::DVD_W'({s_r, 24'b0});
      divisor  = tsta_pkg::DVS_W'(a_eff);
    end else begin
      dividend = tsta_pkg::DVD_W'({sa_r, 8'b0}) + tsta_pkg::DVD_W'({vv_r, 16'b0});
      divisor  = tsta_pkg::DVS_W'(va_r);
    end
  end

  tsta_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (root)
  );

  tsta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign t_full = short_r ? tsta_pkg::DVD_W'(root) : quotient;
  assign t_sat  = |t_full[tsta_pkg::DVD_W-1:tsta_pkg::DUR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dur_r       <= t_sat ? '1 : t_full[tsta_pkg::DUR_W-1:0];
      short_out_r <= short_r;
      sat_out_r   <= t_sat;
    end
  end

  assign status.first_pt  = !have_prev_r || in_start_point;
  assign status.short_seg = short_r;
  assign status.sqrt_busy = sqrt_busy;
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_duration      = dur_r;
  assign out_short_segment = short_out_r;
  assign out_saturated     = sat_out_r;

endmodule

@@ hdl/tsta_ctrl.sv @@
// Controller: sequences the squares, root, limit products, divide and output load.
module tsta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsta_pkg::status_t   status,
  output tsta_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SQ_X      = 4'd1;
  localparam logic [3:0] S_SQ_Y      = 4'd2;
  localparam logic [3:0] S_SQ_Z      = 4'd3;
  localparam logic [3:0] S_ACC       = 4'd4;
  localparam logic [3:0] S_ROOT_GO   = 4'd5;
  localparam logic [3:0] S_ROOT_WAIT = 4'd6;
  localparam logic [3:0] S_MUL_SA    = 4'd7;
  localparam logic [3:0] S_MUL_VV    = 4'd8;
  localparam logic [3:0] S_MUL_VA    = 4'd9;
  localparam logic [3:0] S_CMP       = 4'd10;
  localparam logic [3:0] S_DIV_GO    = 4'd11;
  localparam logic [3:0] S_DIV_WAIT  = 4'd12;
  localparam logic [3:0] S_TIME_GO   = 4'd13;
  localparam logic [3:0] S_TIME_WAIT = 4'd14;
  localparam logic [3:0] S_FIN       = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          // a path start only refreshes the stored point
          if (!status.first_pt) begin
            state_nxt = S_SQ_X;
          end
        end
      end
      S_SQ_X: begin
        cmd.mul_sel = tsta_pkg::MUL_XX;
        state_nxt   = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.mul_sel = tsta_pkg::MUL_YY;
        cmd.acc_add = 1'b1;
        state_nxt   = S_SQ_Z;
      end
      S_SQ_Z: begin
        cmd.mul_sel = tsta_pkg::MUL_ZZ;
        cmd.acc_add = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_src   = tsta_pkg::SQRT_SRC_ACC;
        state_nxt      = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (!status.sqrt_busy) begin
          cmd.s_load = 1'b1;
          state_nxt  = S_MUL_SA;
        end
      end
      S_MUL_SA: begin
        cmd.mul_sel = tsta_pkg::MUL_SA;
        state_nxt   = S_MUL_VV;
      end
      S_MUL_VV: begin
        cmd.mul_sel = tsta_pkg::MUL_VV;
        cmd.sa_load = 1'b1;
        state_nxt   = S_MUL_VA;
      end
      S_MUL_VA: begin
        cmd.mul_sel = tsta_pkg::MUL_VA;
        cmd.vv_load = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.va_load = 1'b1;
        state_nxt   = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = status.short_seg ? S_TIME_GO : S_FIN;
        end
      end
      S_TIME_GO: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_src   = tsta_pkg::SQRT_SRC_QUO;
        state_nxt      = S_TIME_WAIT;
      end
      S_TIME_WAIT: begin
        if (!status.sqrt_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
